// ===== rtl/hon_pkg.sv =====
// Package for the hemi-octahedral normal encoder.
// Holds the widths and the record that travels down the divider chain.
// No dependencies.
`timescale 1ns / 1ps

package hon_pkg;

  // Byte width of the color components and of the encoded outputs.
  localparam int unsigned ByteW = 8;
  // Number of quotient bits, one cell per bit.
  localparam int unsigned QuotW = 8;
  // S lies in 1..765.
  localparam int unsigned SumW = 10;
  // Numerator 255*(v+S)+S lies in 0..390915.
  localparam int unsigned NumW = 19;
  // Divisor 2S is shifted up by QuotW-1 ahead of the first cell.
  localparam int unsigned DenW = SumW + 1 + QuotW - 1;

  // One request in flight between two cells.
  typedef struct packed {
    logic             valid;
    logic             eoi;
    logic [NumW-1:0]  rem_sum;
    logic [NumW-1:0]  rem_diff;
    logic [DenW-1:0]  den;
    logic [QuotW-1:0] q_sum;
    logic [QuotW-1:0] q_diff;
  } cell_t;

endpackage

// ===== rtl/hemi_octahedral_normal_encode.sv =====
// Top level of the hemi-octahedral normal encoder.
// Depends on hon_pkg, hon_front and hon_div_cell.
`timescale 1ns / 1ps

// Usage:
// A request (one RGB normal-map pixel plus an end-of-image flag) is taken at
// each rising edge where start is high and busy is low. busy never rises,
// so one pixel can be sent on every clock.
// The front stage mirrors blue, forms S=|X|+|Y|+|Z| and the numerators
// 255*(X+-Y+S)+S, and registers them. A row of eight identical divider cells then
// settles one quotient bit per cycle for both channels, dividing by 2S.
// The result appears on enc_sum_o, enc_diff_o and end_of_image_out_o,
// marked by valid_o, for exactly one cycle, once the request has passed
// the front register and all eight cell registers.
// Throughput: one pixel per clock, set by the one-bit-per-cell chain that
// holds up to nine requests at once.
// The receiver cannot hold results off, so nothing ever waits.
// Reset clears every valid bit in the chain; requests in flight are dropped.

module hemi_octahedral_normal_encode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [hon_pkg::ByteW-1:0] red_in_i,
  input  logic [hon_pkg::ByteW-1:0] green_in_i,
  input  logic [hon_pkg::ByteW-1:0] blue_in_i,
  input  logic                      end_of_image_i,
  output logic                      valid_o,
  output logic [hon_pkg::ByteW-1:0] enc_sum_o,
  output logic [hon_pkg::ByteW-1:0] enc_diff_o,
  output logic                      end_of_image_out_o
);

  hon_pkg::cell_t chain [hon_pkg::QuotW+1];
  logic           req;

  // The chain always advances, so a new request is always welcome.
  assign busy = 1'b0;
  assign req  = start && !busy;

  hon_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .end_of_image_i (end_of_image_i),
    .cell_o         (chain[0])
  );

  // One cell per quotient bit, most significant first.
  for (genvar i = 0; i < hon_pkg::QuotW; i++) begin : g_cell
    hon_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // The quotient never exceeds 255, so it is the output byte as is.
  assign valid_o            = chain[hon_pkg::QuotW].valid;
  assign enc_sum_o          = chain[hon_pkg::QuotW].q_sum;
  assign enc_diff_o         = chain[hon_pkg::QuotW].q_diff;
  assign end_of_image_out_o = chain[hon_pkg::QuotW].eoi;

  // Every result stems from a request that passed the front register and all cells.
  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(req, 9))
    else $error("result without matching request");

  // The final sum remainder stays below the divisor 2S.
  a_final_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (chain[hon_pkg::QuotW].rem_sum < {chain[hon_pkg::QuotW].den, 1'b0}))
    else $error("final remainder out of range");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

endmodule

// ===== rtl/hon_front.sv =====
// Front stage: mirrors blue, forms S and both numerators, and loads the chain.
// Depends on hon_pkg.
`timescale 1ns / 1ps

module hon_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_i,
  input  logic [hon_pkg::ByteW-1:0]    red_in_i,
  input  logic [hon_pkg::ByteW-1:0]    green_in_i,
  input  logic [hon_pkg::ByteW-1:0]    blue_in_i,
  input  logic                         end_of_image_i,
  output hon_pkg::cell_t               cell_o
);

  logic [hon_pkg::ByteW-1:0] blue_m;
  logic [hon_pkg::ByteW-1:0] abs_x;
  logic [hon_pkg::ByteW-1:0] abs_y;
  logic [hon_pkg::ByteW-1:0] abs_z;
  logic signed [11:0]        x_s;
  logic signed [11:0]        y_s;
  logic [hon_pkg::SumW-1:0]  s;
  logic signed [11:0]        t_sum_s;
  logic signed [11:0]        t_diff_s;
  logic [10:0]               t_sum;
  logic [10:0]               t_diff;
  logic [hon_pkg::NumW:0]    num_sum;
  logic [hon_pkg::NumW:0]    num_diff;
  logic                      valid_d, valid_q;
  hon_pkg::cell_t            cell_d, cell_q;

  // Mirror an inward-pointing blue byte, so Z is always at least 1.
  assign blue_m = blue_in_i[7] ? blue_in_i : ~blue_in_i;

  // Signed components are 2c-255; their magnitudes fit in a byte.
  assign x_s = 12'($signed({3'b000, red_in_i, 1'b0})) - 12'sd255;
  assign y_s = 12'($signed({3'b000, green_in_i, 1'b0})) - 12'sd255;
  assign abs_x = red_in_i[7] ? {red_in_i[6:0], 1'b1} : ~{red_in_i[6:0], 1'b0};
  assign abs_y = green_in_i[7] ? {green_in_i[6:0], 1'b1} : ~{green_in_i[6:0], 1'b0};
  assign abs_z = {blue_m[6:0], 1'b1};
  assign s = {2'b00, abs_x} + {2'b00, abs_y} + {2'b00, abs_z};

  // v+S is never negative, so the low bits carry the whole value.
  assign t_sum_s  = x_s + y_s + 12'($signed({2'b00, s}));
  assign t_diff_s = x_s - y_s + 12'($signed({2'b00, s}));
  assign t_sum  = t_sum_s[10:0];
  assign t_diff = t_diff_s[10:0];

  // 255*t + S as (t << 8) - t + S.
  assign num_sum  = {1'b0, t_sum, 8'h00} - {9'd0, t_sum} + {10'd0, s};
  assign num_diff = {1'b0, t_diff, 8'h00} - {9'd0, t_diff} + {10'd0, s};

  // Load the first cell record.
  always_comb begin
    valid_d         = req_i;
    cell_d          = cell_q;
    cell_d.valid    = valid_d;
    cell_d.eoi      = end_of_image_i;
    cell_d.rem_sum  = num_sum[hon_pkg::NumW-1:0];
    cell_d.rem_diff = num_diff[hon_pkg::NumW-1:0];
    cell_d.den      = {s, 1'b0, {(hon_pkg::QuotW-1){1'b0}}};
    cell_d.q_sum    = '0;
    cell_d.q_diff   = '0;
  end

  // Control bit with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded only for a new request.
  always_ff @(posedge clk_i) begin
    if (req_i) begin
      cell_q <= cell_d;
    end
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

// ===== rtl/hon_div_cell.sv =====
// One cell of the divider chain: decides one quotient bit for both channels.
// Depends on hon_pkg.
`timescale 1ns / 1ps

module hon_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hon_pkg::cell_t cell_i,
  output hon_pkg::cell_t cell_o
);

  logic                      ge_sum;
  logic                      ge_diff;
  logic [hon_pkg::NumW-1:0]  den_ext;
  logic                      valid_d, valid_q;
  hon_pkg::cell_t            cell_d, cell_q;

  assign den_ext = {{(hon_pkg::NumW-hon_pkg::DenW){1'b0}}, cell_i.den};
  assign ge_sum  = cell_i.rem_sum >= den_ext;
  assign ge_diff = cell_i.rem_diff >= den_ext;

  // Restoring step: subtract the shifted divisor where it fits, then halve it.
  always_comb begin
    valid_d         = cell_i.valid;
    cell_d          = cell_i;
    cell_d.rem_sum  = ge_sum ? cell_i.rem_sum - den_ext : cell_i.rem_sum;
    cell_d.rem_diff = ge_diff ? cell_i.rem_diff - den_ext : cell_i.rem_diff;
    cell_d.den      = cell_i.den >> 1;
    cell_d.q_sum    = {cell_i.q_sum[hon_pkg::QuotW-2:0], ge_sum};
    cell_d.q_diff   = {cell_i.q_diff[hon_pkg::QuotW-2:0], ge_diff};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload moves on every cycle; an empty slot carries don't-care data.
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

  // Each step leaves a remainder below the divisor it was compared with.
  a_rem_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.valid |-> (cell_o.rem_sum < {cell_o.den, 1'b0}))
    else $error("sum remainder not below divisor");

  a_rem_diff_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.valid |-> (cell_o.rem_diff < {cell_o.den, 1'b0}))
    else $error("diff remainder not below divisor");

  a_valid_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cell_i.valid) |-> cell_o.valid)
    else $error("request lost in divider cell");

endmodule

// ===== tb/tb_hemi_octahedral_normal_encode.sv =====
// Self-checking testbench for the hemi-octahedral normal encoder.
// Drives RGB pixels with random sender gaps and checks each encoded pair
// against an integer predictor. Depends on hon_pkg and hemi_octahedral_normal_encode.
`timescale 1ns / 1ps

module tb_hemi_octahedral_normal_encode;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 170;

  // One encoded pixel as it leaves the block.
  typedef struct packed {
    logic [hon_pkg::ByteW-1:0] enc_sum;
    logic [hon_pkg::ByteW-1:0] enc_diff;
    logic                      eoi;
  } pixel_code_t;

  // Holds the predicted encodings in request order and compares results.
  class pixel_scoreboard;
    pixel_code_t expected_codes[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    // Map a signed sum to a byte: floor((255*(v+S)+S)/(2S)), clamped to 255.
    function logic [hon_pkg::ByteW-1:0] to_byte(int v, int s);
      int num;
      int q;
      num = 255 * (v + s) + s;
      if (num < 0) num = 0;
      q = num / (2 * s);
      if (q > 255) q = 255;
      return q[hon_pkg::ByteW-1:0];
    endfunction

    // Work out the encoding of one pixel.
    function pixel_code_t encode_pixel(logic [hon_pkg::ByteW-1:0] r,
                                       logic [hon_pkg::ByteW-1:0] g,
                                       logic [hon_pkg::ByteW-1:0] b, logic eoi);
      int x;
      int y;
      int z;
      int s;
      int bz;
      pixel_code_t code;
      bz = int'(b);
      // An inward-pointing normal is mirrored onto the upper hemisphere.
      if (bz < 128) bz = 255 - bz;
      x = 2 * int'(r) - 255;
      y = 2 * int'(g) - 255;
      z = 2 * bz - 255;
      s = (x < 0 ? -x : x) + (y < 0 ? -y : y) + (z < 0 ? -z : z);
      if (s < 1) s = 1;
      code.enc_sum  = to_byte(x + y, s);
      code.enc_diff = to_byte(x - y, s);
      code.eoi      = eoi;
      return code;
    endfunction

    function void note_request(logic [hon_pkg::ByteW-1:0] r,
                               logic [hon_pkg::ByteW-1:0] g,
                               logic [hon_pkg::ByteW-1:0] b, logic eoi);
      expected_codes.push_back(encode_pixel(r, g, b, eoi));
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(pixel_code_t got);
      pixel_code_t want;
      if (expected_codes.size() == 0) begin
        report($sformatf("result with no request pending (sum %0d diff %0d)",
                         got.enc_sum, got.enc_diff));
      end else begin
        want = expected_codes.pop_front();
        checked++;
        if (got.enc_sum !== want.enc_sum)
          report($sformatf("enc_sum got %0d want %0d", got.enc_sum, want.enc_sum));
        if (got.enc_diff !== want.enc_diff)
          report($sformatf("enc_diff got %0d want %0d", got.enc_diff, want.enc_diff));
        if (got.eoi !== want.eoi)
          report($sformatf("end_of_image got %0b want %0b", got.eoi, want.eoi));
      end
    endtask

    function int pending();
      return expected_codes.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [hon_pkg::ByteW-1:0] red_in_i;
  logic [hon_pkg::ByteW-1:0] green_in_i;
  logic [hon_pkg::ByteW-1:0] blue_in_i;
  logic                      end_of_image_i;
  logic                      valid_o;
  logic [hon_pkg::ByteW-1:0] enc_sum_o;
  logic [hon_pkg::ByteW-1:0] enc_diff_o;
  logic                      end_of_image_out_o;

  pixel_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     pixels_sent;
  int unsigned     eoi_sent;
  int unsigned     cycle_count;

  hemi_octahedral_normal_encode dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .red_in_i           (red_in_i),
    .green_in_i         (green_in_i),
    .blue_in_i          (blue_in_i),
    .end_of_image_i     (end_of_image_i),
    .valid_o            (valid_o),
    .enc_sum_o          (enc_sum_o),
    .enc_diff_o         (enc_diff_o),
    .end_of_image_out_o (end_of_image_out_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch the ports: note each accepted request and check each result.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (start && !busy) begin
        sb.note_request(red_in_i, green_in_i, blue_in_i, end_of_image_i);
        pixels_sent++;
        if (end_of_image_i) eoi_sent++;
      end
      if (valid_o) sb.check_result({enc_sum_o, enc_diff_o, end_of_image_out_o});
    end
  end

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one request, after a random number of idle cycles, and hold it
  // until the block takes it.
  task automatic send_pixel(input logic [hon_pkg::ByteW-1:0] r,
                            input logic [hon_pkg::ByteW-1:0] g,
                            input logic [hon_pkg::ByteW-1:0] b, input logic eoi);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    red_in_i       <= r;
    green_in_i     <= g;
    blue_in_i      <= b;
    end_of_image_i <= eoi;
    do @(posedge clk_i); while (busy);
  endtask

  // A random pixel, often near the zero point or at the extremes.
  task automatic send_random_pixel();
    logic [hon_pkg::ByteW-1:0] c[3];
    int unsigned               shape;
    shape = $urandom_range(3);
    for (int k = 0; k < 3; k++) begin
      case (shape)
        0: c[k] = 8'($urandom_range(255));
        1: c[k] = 8'($urandom_range(135, 120));
        2: c[k] = ($urandom_range(1) != 0) ? 8'($urandom_range(255, 248))
                                           : 8'($urandom_range(7));
        default: c[k] = ($urandom_range(2) == 0) ? 8'($urandom_range(130, 125))
                                                 : 8'($urandom_range(255));
      endcase
    end
    send_pixel(c[0], c[1], c[2], $urandom_range(15) == 0);
  endtask

  initial begin
    sb          = new();
    pixels_sent = 0;
    eoi_sent    = 0;
    cycle_count = 0;
    idle_pct    = 0;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    red_in_i       <= '0;
    green_in_i     <= '0;
    blue_in_i      <= '0;
    end_of_image_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels: corners, the zero point, and both sides of the
    // blue mirror boundary, with the end-of-image flag set on some.
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd127, 8'd127, 8'd127, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd127, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd0,   1'b0);
    send_pixel(8'd128, 8'd128, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd128, 1'b0);
    send_pixel(8'd0,   8'd0,   8'd128, 1'b1);
    send_pixel(8'd255, 8'd0,   8'd128, 1'b0);
    send_pixel(8'd0,   8'd255, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd128, 8'd0,   8'd128, 1'b0);
    send_pixel(8'd170, 8'd85,  8'd1,   1'b0);
    send_pixel(8'd85,  8'd170, 8'd254, 1'b1);
    send_pixel(8'hAA,  8'h55,  8'hAA,  1'b0);
    send_pixel(8'h55,  8'hAA,  8'h55,  1'b0);

    // Random pixels under several sender idle patterns: back to back,
    // sparse, back to back again, and lightly gapped.
    for (int p = 0; p < 4; p++) begin
      case (p)
        1:       idle_pct = 81;
        3:       idle_pct = 22;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < PhaseItems; i++) send_random_pixel();
    end
    start <= 1'b0;

    // Let every pixel in flight come out, then a few more cycles.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Encoded %0d pixels (%0d with end-of-image) across four idle patterns;",
             pixels_sent, eoi_sent);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
